FILE: rtl/core/rhf_pkg.sv
// Package for the RF remote header filter: phase codes, decoder state struct,
// field widths and default constants. No dependencies.
package rhf_pkg;

    localparam int TICKS_PER_US_DEFAULT = 1;

    localparam int LEN_W      = 24;
    localparam int NODE_ID_W  = 8;
    localparam int MASK_W     = 7;
    localparam int ADDR_W     = 12;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Header layout, in edges after the header pulse
    localparam logic [COUNT_W-1:0] EDGE_FIRST_ADDR = 7'd4;
    localparam logic [COUNT_W-1:0] EDGE_GROUP_2    = 7'd26;
    localparam logic [COUNT_W-1:0] EDGE_GROUP_3    = 7'd48;
    localparam logic [COUNT_W-1:0] EDGE_DECIDE     = 7'd71;

    localparam logic [NODE_ID_W-1:0] ID_PASS_ALL    = 8'd0;
    localparam logic [NODE_ID_W-1:0] ID_HEADER_ONLY = 8'd254;
    localparam logic [NODE_ID_W-1:0] ID_RAW         = 8'd255;

    localparam logic [MASK_W-1:0]    MASK_RESET     = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_ID      = 1'b0,
        REG_CHANNEL_MASK = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_BYPASS  = 2'd2,
        PH_INVALID = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic                pass_flag;
        logic [COUNT_W-1:0]  edge_count;
        logic [ADDR_W-1:0]   shift_word;
        logic [ADDR_W-1:0]   captured_address;
        logic                pin_level;
    } rhf_state_t;

    localparam rhf_state_t STATE_RESET = '{
        phase:            PH_IDLE,
        pass_flag:        1'b0,
        edge_count:       '0,
        shift_word:       '0,
        captured_address: '0,
        pin_level:        1'b1
    };

endpackage

FILE: rtl/core/rhf_edge_if.sv
// Edge event channel: level that ended and its length in ticks.
// Depends on rhf_pkg for field widths.
interface rhf_edge_if;
    logic                     valid;
    logic                     ready;
    logic                     ended_pulse;
    logic [rhf_pkg::LEN_W-1:0] length_ticks;

    modport source (output valid, output ended_pulse, output length_ticks, input ready);
    modport sink   (input valid, input ended_pulse, input length_ticks, output ready);
endinterface

FILE: rtl/core/rhf_result_if.sv
// Result channel: output line level, forwarding flag, phase and address.
// Depends on rhf_pkg for field widths.
interface rhf_result_if;
    logic                       valid;
    logic                       ready;
    logic                       out_pin;
    logic                       forwarding;
    logic [1:0]                 decoder_phase;
    logic [rhf_pkg::ADDR_W-1:0] address;

    modport source (output valid, output out_pin, output forwarding,
                    output decoder_phase, output address, input ready);
    modport sink   (input valid, input out_pin, input forwarding,
                    input decoder_phase, input address, output ready);
endinterface

FILE: rtl/core/rhf_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on rhf_pkg for widths.
interface rhf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rhf_pkg::CFG_IDX_W-1:0]  index;
    logic [rhf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/rf_remote_header_filter_unit.sv
// RF remote header filter, top level: decoder state, configuration registers
// and the result register. Depends on rhf_pkg, the three channel interfaces
// and rhf_decode.
//
// A result is valid the cycle after its edge transaction is accepted.
// Throughput: one edge per clock while results are taken; the single result
//   register takes a new result in the same cycle the previous one is taken.
// Reset (rst_n, async low): phase idle, pass flag clear, stored line level high,
//   node_id 6, channel_mask 127, no result pending.
module rf_remote_header_filter_unit #(
    parameter int TICKS_PER_US = rhf_pkg::TICKS_PER_US_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rhf_edge_if.sink             edges,
    rhf_result_if.source         results,
    rhf_cfg_if.sink              cfg
);
    import rhf_pkg::*;

    // Decoder state; updated once per accepted edge transaction
    rhf_state_t state_reg;
    rhf_state_t state_next;

    // Configuration registers
    logic [NODE_ID_W-1:0] node_id_reg;
    logic [MASK_W-1:0]    channel_mask_reg;

    // Result register
    logic                 out_valid_reg;
    logic                 out_pin_reg;
    logic                 forwarding_reg;
    logic [1:0]           phase_out_reg;
    logic [ADDR_W-1:0]    address_reg;

    logic edge_accept;
    logic cfg_accept;

    // Accept a new edge when the result slot is empty or being drained
    assign edges.ready = !out_valid_reg || results.ready;
    assign edge_accept = edges.valid && edges.ready;

    assign cfg.ready  = 1'b1;
    assign cfg_accept = cfg.valid && cfg.ready;

    rhf_decode #(
        .TICKS_PER_US (TICKS_PER_US)
    ) u_decode (
        .cur          (state_reg),
        .ended_pulse  (edges.ended_pulse),
        .length_ticks (edges.length_ticks),
        .node_id      (node_id_reg),
        .channel_mask (channel_mask_reg),
        .nxt          (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (edge_accept)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg      <= NODE_ID_W'(6);
            channel_mask_reg <= MASK_RESET;
        end
        else if (cfg_accept)
        begin
            unique case (cfg.index)
                REG_NODE_ID:      node_id_reg      <= cfg.data;
                REG_CHANNEL_MASK: channel_mask_reg <= cfg.data[MASK_W-1:0];
                default:          node_id_reg      <= node_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (edge_accept)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // Payload: loaded with every accepted transaction, no reset needed
    always_ff @(posedge clk)
    begin
        if (edge_accept)
        begin
            out_pin_reg    <= state_next.pin_level;
            forwarding_reg <= state_next.pass_flag;
            phase_out_reg  <= state_next.phase;
            address_reg    <= state_next.captured_address;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.out_pin       = out_pin_reg;
    assign results.forwarding    = forwarding_reg;
    assign results.decoder_phase = phase_out_reg;
    assign results.address       = address_reg;

    // Header never runs past the decision edge
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_HEADER |-> state_reg.edge_count < EDGE_DECIDE)
        else $error("edge count past decision edge in header");

    // Bypass is only reached from header
    a_bypass_entry: assert property (@(posedge clk) disable iff (!rst_n)
        edge_accept && state_next.phase == PH_BYPASS && state_reg.phase != PH_BYPASS
        |-> state_reg.phase == PH_HEADER)
        else $error("bypass entered from wrong phase");

    // Line level only moves on forwarded edges
    a_pin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        edge_accept && !state_next.pass_flag |=> state_reg.pin_level == $past(state_reg.pin_level))
        else $error("output line moved on a non-forwarded edge");

    // Every accepted transaction yields a pending result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        edge_accept |=> results.valid)
        else $error("accepted edge produced no result");

endmodule

FILE: rtl/core/rhf_decode.sv
// Next-state logic of the header decoder for one edge event.
// Depends on rhf_pkg (state struct, phase codes, constants).
module rhf_decode #(
    parameter int TICKS_PER_US = rhf_pkg::TICKS_PER_US_DEFAULT
) (
    input  rhf_pkg::rhf_state_t               cur,
    input  logic                              ended_pulse,
    input  logic [rhf_pkg::LEN_W-1:0]         length_ticks,
    input  logic [rhf_pkg::NODE_ID_W-1:0]     node_id,
    input  logic [rhf_pkg::MASK_W-1:0]        channel_mask,
    output rhf_pkg::rhf_state_t               nxt
);
    import rhf_pkg::*;

    // Windows 80..120% of nominal, in ticks
    localparam int N_HDR  = 5000 * TICKS_PER_US;
    localparam int N_PART = 500 * TICKS_PER_US;
    localparam int N_BIT  = 250 * TICKS_PER_US;
    localparam int N_GAP  = 200000 * TICKS_PER_US;

    localparam logic [LEN_W-1:0] HDR_LO  = LEN_W'(N_HDR * 4 / 5);
    localparam logic [LEN_W-1:0] HDR_HI  = LEN_W'(N_HDR * 6 / 5);
    localparam logic [LEN_W-1:0] PART_LO = LEN_W'(N_PART * 4 / 5);
    localparam logic [LEN_W-1:0] PART_HI = LEN_W'(N_PART * 6 / 5);
    localparam logic [LEN_W-1:0] BIT_LO  = LEN_W'(N_BIT * 4 / 5);
    localparam logic [LEN_W-1:0] BIT_HI  = LEN_W'(N_BIT * 6 / 5);
    localparam logic [LEN_W-1:0] GAP_MAX = LEN_W'(N_GAP);

    logic win_hdr, win_part, win_bit, long_gap;
    logic [COUNT_W-1:0] cnt;
    logic odd;
    logic id_match;

    assign win_hdr  = (length_ticks >= HDR_LO)  && (length_ticks <= HDR_HI);
    assign win_part = (length_ticks >= PART_LO) && (length_ticks <= PART_HI);
    assign win_bit  = (length_ticks >= BIT_LO)  && (length_ticks <= BIT_HI);
    assign long_gap = !ended_pulse && (length_ticks > GAP_MAX);

    assign cnt = cur.edge_count + 1'b1;
    assign odd = cnt[0];

    // channel bits 4..10; the marker bit never takes part
    assign id_match = (node_id == ID_PASS_ALL) ||
                      (({4'b0, cur.captured_address[3:0]} == node_id) &&
                       ((cur.captured_address[ADDR_W-2:4] & channel_mask) != '0));

    always_comb
    begin
        nxt = cur;

        if (long_gap)
        begin
            nxt.phase     = PH_IDLE;
            nxt.pass_flag = 1'b0;
        end

        unique case (nxt.phase)
            PH_IDLE:
            begin
                if (ended_pulse && win_hdr)
                begin
                    nxt.phase            = PH_HEADER;
                    nxt.pass_flag        = 1'b0;
                    nxt.edge_count       = '0;
                    nxt.captured_address = '0;
                end
            end
            PH_HEADER:
            begin
                nxt.edge_count = cnt;
                // odd edges end a space, even edges end a pulse
                if (ended_pulse == odd)
                begin
                    nxt.phase     = PH_INVALID;
                    nxt.pass_flag = 1'b0;
                end
                else if (cnt < EDGE_FIRST_ADDR)
                begin
                    if (!win_part)
                    begin
                        nxt.phase     = PH_INVALID;
                        nxt.pass_flag = 1'b0;
                    end
                end
                else if (cnt < EDGE_DECIDE)
                begin
                    // marker bit seeds each address group
                    if (cnt == EDGE_FIRST_ADDR || cnt == EDGE_GROUP_2 || cnt == EDGE_GROUP_3)
                        nxt.shift_word = ADDR_W'(1);
                    if (!odd)
                    begin
                        if (!win_bit)
                        begin
                            nxt.phase     = PH_INVALID;
                            nxt.pass_flag = 1'b0;
                        end
                    end
                    else
                    begin
                        nxt.shift_word = {nxt.shift_word[ADDR_W-2:0], 1'b0};
                        if (win_bit)
                        begin
                            nxt.shift_word[0] = 1'b0;
                        end
                        else if (win_part)
                        begin
                            nxt.shift_word[0] = 1'b1;
                        end
                        else
                        begin
                            nxt.phase     = PH_INVALID;
                            nxt.pass_flag = 1'b0;
                        end
                    end
                    if (nxt.shift_word[ADDR_W-1])
                        nxt.captured_address = nxt.shift_word;
                end
                else if (cnt == EDGE_DECIDE)
                begin
                    nxt.phase     = PH_BYPASS;
                    nxt.pass_flag = id_match;
                end
            end
            PH_BYPASS, PH_INVALID:
            begin
                nxt.phase = nxt.phase;
            end
            default:
            begin
                nxt.phase = nxt.phase;
            end
        endcase

        if (node_id == ID_RAW)
            nxt.pass_flag = 1'b1;
        else if (node_id == ID_HEADER_ONLY)
            nxt.pass_flag = (nxt.phase == PH_IDLE) || (nxt.phase == PH_HEADER);

        if (nxt.pass_flag)
            nxt.pin_level = ended_pulse;
    end

endmodule
